FILE: rtl/core/psrm_pkg.sv
// shared types, codes and widths for the page state range marker
package psrm_pkg;

  localparam int PFN_W     = 52;
  localparam int CNT_W     = 17;
  localparam int MODE_W    = 2;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 1;
  localparam int DEF_MAX_PAGES = 65536;

  localparam logic [MODE_W-1:0] MODE_RESV_ALL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESV     = 2'd2;

  localparam logic [ST_W-1:0] ST_FREE     = 2'd0;
  localparam logic [ST_W-1:0] ST_RESERVED = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ALL,
    OP_FREE,
    OP_RESV
  } walk_op_t;

  typedef struct packed {
    logic     start;
    walk_op_t op;
  } walk_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_sts_t;

endpackage

FILE: rtl/core/psrm_if.sv
// request and result channel interfaces
interface psrm_in_if import psrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [PFN_W-1:0]  range_start_page;
  logic [PFN_W-1:0]  range_pages;

  modport source (output valid, mode, range_start_page, range_pages, input ready);
  modport sink   (input valid, mode, range_start_page, range_pages, output ready);
endinterface

interface psrm_out_if import psrm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] pages_changed;
  logic [CNT_W-1:0] free_pages;
  logic [CNT_W-1:0] reserved_pages;

  modport source (output valid, pages_changed, free_pages, reserved_pages, input ready);
  modport sink   (input valid, pages_changed, free_pages, reserved_pages, output ready);
endinterface

FILE: rtl/core/psrm_ram.sv
// generic single write port ram with registered read
module psrm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/psrm_walker.sv
// page walker: read-modify-write over the state store, one page a cycle
module psrm_walker import psrm_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int IW        = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  walk_cmd_t        cmd,
  input  logic [IW-1:0]    first,
  input  logic [IW-1:0]    last,
  input  logic [CNT_W-1:0] win,
  output walk_sts_t        sts,
  output logic [CNT_W-1:0] changed,
  output logic [CNT_W-1:0] free_cnt,
  output logic [CNT_W-1:0] resv_cnt
);

  localparam int AW = $clog2(MAX_PAGES);

  typedef enum logic [1:0] {W_IDLE, W_RUN, W_DONE} wstate_t;

  wstate_t          st_r;
  walk_op_t         op_r;
  logic [IW-1:0]    idx_r, last_r, pidx_r;
  logic             pend_r;
  logic [CNT_W-1:0] changed_r, free_r, resv_r, win_r;

  logic             more, is_clr, rd_en, chg, fin, ram_we;
  logic [AW-1:0]    waddr;
  logic [ST_W-1:0]  wdata, rdata, new_st;

  always_comb begin
    more   = idx_r < last_r;
    is_clr = (op_r == OP_CLEAR);
    rd_en  = (st_r == W_RUN) && more && !is_clr;
    case (op_r)
      OP_ALL:  chg = pend_r && (rdata != ST_RESERVED);
      OP_FREE: chg = pend_r && (rdata == ST_RESERVED);
      OP_RESV: chg = pend_r && (rdata == ST_FREE);
      default: chg = 1'b0;
    endcase
    new_st = (op_r == OP_FREE) ? ST_FREE : ST_RESERVED;
    ram_we = (st_r == W_RUN) && (is_clr ? more : chg);
    waddr  = is_clr ? idx_r[AW-1:0] : pidx_r[AW-1:0];
    wdata  = is_clr ? ST_FREE : new_st;
    fin    = (st_r == W_RUN) && !more && !pend_r;
  end

  psrm_ram #(.WIDTH(ST_W), .DEPTH(MAX_PAGES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= W_IDLE;
      op_r      <= OP_NONE;
      idx_r     <= '0;
      last_r    <= '0;
      pidx_r    <= '0;
      pend_r    <= 1'b0;
      changed_r <= '0;
      free_r    <= '0;
      resv_r    <= '0;
      win_r     <= '0;
    end else begin
      case (st_r)
        W_IDLE: begin
          pend_r <= 1'b0;
          if (cmd.start) begin
            st_r      <= W_RUN;
            op_r      <= cmd.op;
            idx_r     <= first;
            last_r    <= last;
            win_r     <= win;
            changed_r <= '0;
          end
        end
        W_RUN: begin
          pend_r <= rd_en;
          pidx_r <= idx_r;
          if (more) begin
            idx_r <= idx_r + IW'(1);
          end
          if (chg) begin
            changed_r <= changed_r + CNT_W'(1);
            if (op_r == OP_FREE) begin
              free_r <= free_r + CNT_W'(1);
              resv_r <= (resv_r == '0) ? '0 : resv_r - CNT_W'(1);
            end else if (op_r == OP_RESV) begin
              free_r <= (free_r == '0) ? '0 : free_r - CNT_W'(1);
              resv_r <= resv_r + CNT_W'(1);
            end
          end
          if (fin) begin
            st_r <= W_DONE;
            if (op_r == OP_ALL) begin
              resv_r <= win_r;
              free_r <= '0;
            end
          end
        end
        W_DONE: begin
          st_r <= W_IDLE;
        end
        default: begin
          st_r <= W_IDLE;
        end
      endcase
    end
  end

  assign sts.busy = (st_r != W_IDLE);
  assign sts.done = (st_r == W_DONE);
  assign changed  = changed_r;
  assign free_cnt = free_r;
  assign resv_cnt = resv_r;

  a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == W_DONE) |=> (st_r == W_IDLE))
    else $error("walker done lasted more than one cycle");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != W_RUN) |-> !ram_we)
    else $error("state store written outside a walk");

  a_pend_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ($past(st_r) == W_RUN))
    else $error("read data pending without a walk");

endmodule

FILE: rtl/core/page_state_range_marker.sv
// top level: config registers, range clipping sequencer, result register
// the walker covers the pages in the clipped range (the whole window for reserve-all)
// throughput: one request at a time, the walker's single write port into the store sets the pace
// a waiting result does not hold up the next request until it finishes
// reset: counters and control registers clear, then a clearing pass over the whole store
// frees every page; in_ch.ready stays low during the pass
module page_state_range_marker import psrm_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [PFN_W-1:0]     cfg_wdata,
  psrm_in_if.sink              in_ch,
  psrm_out_if.source           out_ch
);

  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int IW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [2:0] {
    T_INIT, T_CLR, T_IDLE, T_CALC1, T_CALC2, T_CALC3, T_WAIT, T_OUT
  } tstate_t;

  tstate_t           st_r;
  logic [PFN_W-1:0]  base_r;
  logic [CNT_W-1:0]  pages_r;
  logic [MODE_W-1:0] mode_r;
  logic [PFN_W-1:0]  start_r, count_r, cs_r;
  logic [PFN_W:0]    rend_r, wend_r, ce_r;
  walk_cmd_t         cmd_r;
  logic [IW-1:0]     first_r, last_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_chg_r, out_free_r, out_resv_r;

  logic [CNT_W-1:0]  win;
  walk_sts_t         wsts;
  logic [CNT_W-1:0]  w_changed, w_free, w_resv;
  logic              hit, out_load;
  logic [PFN_W-1:0]  first_full;
  logic [PFN_W:0]    last_full;

  always_comb begin
    win = (32'(pages_r) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : pages_r;
    hit = (count_r != '0) && ({1'b0, cs_r} < ce_r) &&
          ((mode_r == MODE_FREE) || (mode_r == MODE_RESV));
    first_full = cs_r - base_r;
    last_full  = ce_r - {1'b0, base_r};
    out_load   = (st_r == T_OUT) && (!out_valid_r || out_ch.ready);
  end

  psrm_walker #(.MAX_PAGES(MAX_PAGES), .IW(IW)) u_walker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd_r),
    .first    (first_r),
    .last     (last_r),
    .win      (win),
    .sts      (wsts),
    .changed  (w_changed),
    .free_cnt (w_free),
    .resv_cnt (w_resv)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      pages_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BASE:  base_r  <= cfg_wdata;
        CFG_PAGES: pages_r <= cfg_wdata[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_INIT;
      cmd_r       <= '{start: 1'b0, op: OP_NONE};
      first_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_chg_r   <= w_changed;
        out_free_r  <= w_free;
        out_resv_r  <= w_resv;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        T_INIT: begin
          cmd_r   <= '{start: 1'b1, op: OP_CLEAR};
          first_r <= '0;
          last_r  <= IW'(MAX_PAGES);
          st_r    <= T_CLR;
        end
        T_CLR: begin
          cmd_r.start <= 1'b0;
          if (wsts.done) begin
            st_r <= T_IDLE;
          end
        end
        T_IDLE: begin
          cmd_r.start <= 1'b0;
          if (in_ch.valid) begin
            mode_r  <= in_ch.mode;
            start_r <= in_ch.range_start_page;
            count_r <= in_ch.range_pages;
            st_r    <= T_CALC1;
          end
        end
        T_CALC1: begin
          cmd_r.start <= 1'b0;
          // range and window ends, one bit wider so they never wrap
          rend_r <= {1'b0, start_r} + {1'b0, count_r};
          wend_r <= {1'b0, base_r} + (PFN_W+1)'(win);
          st_r   <= T_CALC2;
        end
        T_CALC2: begin
          cmd_r.start <= 1'b0;
          cs_r <= (start_r < base_r) ? base_r : start_r;
          ce_r <= (rend_r > wend_r) ? wend_r : rend_r;
          st_r <= T_CALC3;
        end
        T_CALC3: begin
          if (mode_r == MODE_RESV_ALL) begin
            cmd_r   <= '{start: 1'b1, op: OP_ALL};
            first_r <= '0;
            last_r  <= IW'(win);
          end else if (hit) begin
            cmd_r   <= '{start: 1'b1, op: (mode_r == MODE_FREE) ? OP_FREE : OP_RESV};
            first_r <= IW'(first_full[CNT_W-1:0]);
            last_r  <= IW'(last_full[CNT_W-1:0]);
          end else begin
            cmd_r   <= '{start: 1'b1, op: OP_NONE};
            first_r <= '0;
            last_r  <= '0;
          end
          st_r <= T_WAIT;
        end
        T_WAIT: begin
          cmd_r.start <= 1'b0;
          if (wsts.done) begin
            st_r <= T_OUT;
          end
        end
        T_OUT: begin
          cmd_r.start <= 1'b0;
          if (out_load) begin
            st_r <= T_IDLE;
          end
        end
        default: begin
          cmd_r.start <= 1'b0;
          st_r <= T_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready           = (st_r == T_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.pages_changed  = out_chg_r;
  assign out_ch.free_pages     = out_free_r;
  assign out_ch.reserved_pages = out_resv_r;

  a_idle_walker_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == T_IDLE) |-> !wsts.busy)
    else $error("walker busy while accepting requests");

  a_transfer_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (st_r == T_CALC1))
    else $error("accepted request did not start range clipping");

  a_load_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> ($past(st_r) == T_WAIT || $past(st_r) == T_OUT))
    else $error("result loaded without a finished walk");

endmodule
